/* rtl/tbw_pkg.sv */
// shared constants and types of the tetrahedral barycentric weights core
`default_nettype none

package tbw_pkg;

  // component width of vertices and colors (values above 16 behave as 16)
  localparam int COMPONENT_BITS = 16;
  localparam int CW = (COMPONENT_BITS > 16) ? 16 : COMPONENT_BITS;

  // port widths
  localparam int IN_W      = 16;
  localparam int REG_W     = 48;
  localparam int OUT_W     = 24;
  localparam int CFG_IDX_W = 8;

  // three color channels
  localparam int NUM_COMP = 3;

  // internal arithmetic widths
  localparam int EW = CW + 1;          // edge or offset component
  localparam int PW = 2 * EW;          // product of a pair of edge components
  localparam int XW = PW + 1;          // cross product component
  localparam int DW = 3 * EW + 4;      // determinants, with room for weight d

  // quotient format before rounding: 7 integer bits, 17 fraction bits
  localparam int WQ_INT    = 7;
  localparam int WQ_FRAC   = 17;
  localparam int WQ_BITS   = WQ_INT + WQ_FRAC;
  localparam int DIV_STEPS = WQ_BITS;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_D = CFG_IDX_W'(3);

  typedef logic signed [IN_W-1:0]  color_comp_t;
  typedef logic signed [OUT_W-1:0] weight_t;
  typedef logic [REG_W-1:0]        vertex_t;
  typedef logic signed [DW-1:0]    det_t;

  typedef struct packed {
    vertex_t vertex_a;
    vertex_t vertex_b;
    vertex_t vertex_c;
    vertex_t vertex_d;
  } gamut_t;

  typedef struct packed {
    color_comp_t color_red;
    color_comp_t color_green;
    color_comp_t color_blue;
  } color_t;

  typedef struct packed {
    det_t det;
    det_t det_a;
    det_t det_b;
    det_t det_c;
    det_t det_d;
  } det_res_t;

  typedef struct packed {
    weight_t weight_a;
    weight_t weight_b;
    weight_t weight_c;
    weight_t weight_d;
    logic    degenerate;
  } weights_t;

endpackage

`default_nettype wire

/* rtl/tbw_ifs.sv */
// request channels of the core: color input, weights output, register writes
`default_nettype none

interface tbw_color_if import tbw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [IN_W-1:0]    color_red;
  logic signed [IN_W-1:0]    color_green;
  logic signed [IN_W-1:0]    color_blue;

  modport source (output valid, output color_red, output color_green, output color_blue,
                  input ready);
  modport sink (input valid, input color_red, input color_green, input color_blue,
                output ready);
endinterface

interface tbw_weights_if import tbw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [OUT_W-1:0]   weight_a;
  logic signed [OUT_W-1:0]   weight_b;
  logic signed [OUT_W-1:0]   weight_c;
  logic signed [OUT_W-1:0]   weight_d;
  logic                      degenerate;

  modport source (output valid, output weight_a, output weight_b, output weight_c,
                  output weight_d, output degenerate, input ready);
  modport sink (input valid, input weight_a, input weight_b, input weight_c,
                input weight_d, input degenerate, output ready);
endinterface

interface tbw_cfg_if import tbw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_IDX_W-1:0]      index;
  logic [REG_W-1:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/tbw_cfg_regs.sv */
// gamut vertex registers and their write decode
`default_nettype none

module tbw_cfg_regs import tbw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tbw_cfg_if.sink   cfg,
  output gamut_t    gamut
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamut <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_VERTEX_A: gamut.vertex_a <= cfg.data;
        REG_VERTEX_B: gamut.vertex_b <= cfg.data;
        REG_VERTEX_C: gamut.vertex_c <= cfg.data;
        REG_VERTEX_D: gamut.vertex_d <= cfg.data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/tbw_det.sv */
// determinant pipeline: edges, cross products, triple products (six stages)
`default_nettype none

module tbw_det import tbw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  logic     in_valid,
  input  color_t   color,
  input  gamut_t   gamut,
  output logic     res_valid,
  output det_res_t res
);

  typedef logic signed [EW-1:0] edge_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [XW-1:0] cross_t;

  // component k of a packed vertex, sign extended
  function automatic edge_t comp_of(vertex_t r, int k);
    logic signed [CW-1:0] c;
    c = r[CW*k +: CW];
    return EW'(c);
  endfunction

  function automatic edge_t color_ext(color_comp_t v);
    logic signed [CW-1:0] c;
    c = v[CW-1:0];
    return EW'(c);
  endfunction

  color_comp_t col [NUM_COMP];
  edge_t       ea_c [NUM_COMP];
  edge_t       eb_c [NUM_COMP];
  edge_t       ec_c [NUM_COMP];
  edge_t       q_c  [NUM_COMP];

  assign col[0] = color.color_red;
  assign col[1] = color.color_green;
  assign col[2] = color.color_blue;

  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      ea_c[k] = comp_of(gamut.vertex_a, k) - comp_of(gamut.vertex_d, k);
      eb_c[k] = comp_of(gamut.vertex_b, k) - comp_of(gamut.vertex_d, k);
      ec_c[k] = comp_of(gamut.vertex_c, k) - comp_of(gamut.vertex_d, k);
      q_c[k]  = color_ext(col[k]) - comp_of(gamut.vertex_d, k);
    end
  end

  // stage 1: edges and color offset
  logic  vld1;
  edge_t ea1 [NUM_COMP];
  edge_t eb1 [NUM_COMP];
  edge_t ec1 [NUM_COMP];
  edge_t q1  [NUM_COMP];

  // stage 2: cross product terms
  logic  vld2;
  edge_t ea2 [NUM_COMP];
  edge_t q2  [NUM_COMP];
  prod_t pn_a [NUM_COMP];
  prod_t pn_b [NUM_COMP];
  prod_t pu_a [NUM_COMP];
  prod_t pu_b [NUM_COMP];
  prod_t pv_a [NUM_COMP];
  prod_t pv_b [NUM_COMP];

  // stage 3: cross products n = b x c, u = c x a, v = a x b
  logic   vld3;
  edge_t  ea3 [NUM_COMP];
  edge_t  q3  [NUM_COMP];
  cross_t xn3 [NUM_COMP];
  cross_t xu3 [NUM_COMP];
  cross_t xv3 [NUM_COMP];

  // stage 4: dot product terms
  logic vld4;
  det_t td4 [NUM_COMP];
  det_t ta4 [NUM_COMP];
  det_t tb4 [NUM_COMP];
  det_t tc4 [NUM_COMP];

  // stage 5: determinants
  logic vld5;
  det_t det5;
  det_t da5;
  det_t db5;
  det_t dc5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      vld3      <= 1'b0;
      vld4      <= 1'b0;
      vld5      <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      vld1      <= in_valid;
      vld2      <= vld1;
      vld3      <= vld2;
      vld4      <= vld3;
      vld5      <= vld4;
      res_valid <= vld5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ea1 <= ea_c;
      eb1 <= eb_c;
      ec1 <= ec_c;
      q1  <= q_c;
      ea2 <= ea1;
      q2  <= q1;
      ea3 <= ea2;
      q3  <= q2;
      det5 <= td4[0] + td4[1] + td4[2];
      da5  <= ta4[0] + ta4[1] + ta4[2];
      db5  <= tb4[0] + tb4[1] + tb4[2];
      dc5  <= tc4[0] + tc4[1] + tc4[2];
      res.det   <= det5;
      res.det_a <= da5;
      res.det_b <= db5;
      res.det_c <= dc5;
      res.det_d <= det5 - da5 - db5 - dc5;
    end
  end

  for (genvar k = 0; k < NUM_COMP; k++) begin : g_comp
    localparam int K1 = (k + 1) % NUM_COMP;
    localparam int K2 = (k + 2) % NUM_COMP;

    always_ff @(posedge clk) begin
      if (advance) begin
        pn_a[k] <= prod_t'(eb1[K1]) * prod_t'(ec1[K2]);
        pn_b[k] <= prod_t'(eb1[K2]) * prod_t'(ec1[K1]);
        pu_a[k] <= prod_t'(ec1[K1]) * prod_t'(ea1[K2]);
        pu_b[k] <= prod_t'(ec1[K2]) * prod_t'(ea1[K1]);
        pv_a[k] <= prod_t'(ea1[K1]) * prod_t'(eb1[K2]);
        pv_b[k] <= prod_t'(ea1[K2]) * prod_t'(eb1[K1]);
        xn3[k]  <= cross_t'(pn_a[k]) - cross_t'(pn_b[k]);
        xu3[k]  <= cross_t'(pu_a[k]) - cross_t'(pu_b[k]);
        xv3[k]  <= cross_t'(pv_a[k]) - cross_t'(pv_b[k]);
        td4[k]  <= det_t'(ea3[k]) * det_t'(xn3[k]);
        ta4[k]  <= det_t'(q3[k]) * det_t'(xn3[k]);
        tb4[k]  <= det_t'(q3[k]) * det_t'(xu3[k]);
        tc4[k]  <= det_t'(q3[k]) * det_t'(xv3[k]);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/tbw_div.sv */
// pipelined restoring divider, one quotient bit per stage, with rounding
`default_nettype none

module tbw_div import tbw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  logic     in_valid,
  input  det_res_t in_det,
  output logic     res_valid,
  output weights_t res
);

  localparam int NUM_W = 4;

  typedef logic [DW-1:0] mag_t;

  typedef struct packed {
    mag_t               rem;
    logic [WQ_BITS-1:0] quo;
    logic [WQ_INT-1:0]  lo;
    logic               neg;
    logic               ovf;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_W-1:0] lane;
    mag_t              den;
    logic              degen;
  } stage_t;

  localparam logic [WQ_BITS:0] NEG_MAG = (WQ_BITS+1)'(1) << (OUT_W - 1);
  localparam logic [WQ_BITS:0] POS_MAX = NEG_MAG - (WQ_BITS+1)'(1);
  localparam logic [WQ_BITS:0] SAT_MAG = NEG_MAG + (WQ_BITS+1)'(1);

  function automatic mag_t abs_of(det_t x);
    return x[DW-1] ? mag_t'(-x) : mag_t'(x);
  endfunction

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic lane_t div_step(lane_t l, mag_t den);
    lane_t o;
    mag_t  sh;
    sh = {l.rem[DW-2:0], l.lo[WQ_INT-1]};
    o = l;
    o.lo = {l.lo[WQ_INT-2:0], 1'b0};
    if (sh >= den) begin
      o.rem = sh - den;
      o.quo = {l.quo[WQ_BITS-2:0], 1'b1};
    end else begin
      o.rem = sh;
      o.quo = {l.quo[WQ_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  // round half away from zero, then clamp to the output range
  function automatic weight_t round_sat(lane_t l);
    logic [WQ_BITS:0] mag;
    logic [WQ_BITS:0] neg_mag;
    if (l.ovf) begin
      mag = SAT_MAG;
    end else begin
      mag = ({1'b0, l.quo} + {{WQ_BITS{1'b0}}, 1'b1}) >> 1;
    end
    neg_mag = (mag > NEG_MAG) ? NEG_MAG : mag;
    if (!l.neg) begin
      return (mag > POS_MAX) ? weight_t'(POS_MAX[OUT_W-1:0]) : weight_t'(mag[OUT_W-1:0]);
    end
    return weight_t'(neg_mag[OUT_W-1:0] ^ {OUT_W{1'b1}}) + weight_t'(1);
  endfunction

  det_t nums [NUM_W];

  assign nums[0] = in_det.det_a;
  assign nums[1] = in_det.det_b;
  assign nums[2] = in_det.det_c;
  assign nums[3] = in_det.det_d;

  // prep stage 1: magnitudes and signs
  logic p1_valid;
  logic p1_degen;
  mag_t p1_den;
  mag_t p1_num [NUM_W];
  logic p1_neg [NUM_W];

  stage_t stg       [DIV_STEPS+1];
  logic   stg_valid [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid     <= 1'b0;
      stg_valid[0] <= 1'b0;
      res_valid    <= 1'b0;
    end else if (advance) begin
      p1_valid     <= in_valid;
      stg_valid[0] <= p1_valid;
      res_valid    <= stg_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_degen <= (in_det.det == '0);
      p1_den   <= abs_of(in_det.det);
      for (int w = 0; w < NUM_W; w++) begin
        p1_num[w] <= abs_of(nums[w]);
        p1_neg[w] <= nums[w][DW-1] ^ in_det.det[DW-1];
      end
      // prep stage 2: overflow test and divider seed
      stg[0].den   <= p1_den;
      stg[0].degen <= p1_degen;
      for (int w = 0; w < NUM_W; w++) begin
        stg[0].lane[w].rem <= p1_num[w] >> WQ_INT;
        stg[0].lane[w].quo <= '0;
        stg[0].lane[w].lo  <= p1_num[w][WQ_INT-1:0];
        stg[0].lane[w].neg <= p1_neg[w];
        stg[0].lane[w].ovf <= {{WQ_INT{1'b0}}, p1_num[w]} >= {p1_den, {WQ_INT{1'b0}}};
      end
      // final stage: round, saturate, zero on singular gamut
      if (stg[DIV_STEPS].degen) begin
        res.weight_a   <= '0;
        res.weight_b   <= '0;
        res.weight_c   <= '0;
        res.weight_d   <= '0;
        res.degenerate <= 1'b1;
      end else begin
        res.weight_a   <= round_sat(stg[DIV_STEPS].lane[0]);
        res.weight_b   <= round_sat(stg[DIV_STEPS].lane[1]);
        res.weight_c   <= round_sat(stg[DIV_STEPS].lane[2]);
        res.weight_d   <= round_sat(stg[DIV_STEPS].lane[3]);
        res.degenerate <= 1'b0;
      end
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[s+1] <= 1'b0;
      end else if (advance) begin
        stg_valid[s+1] <= stg_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        stg[s+1].den   <= stg[s].den;
        stg[s+1].degen <= stg[s].degen;
        for (int w = 0; w < NUM_W; w++) begin
          stg[s+1].lane[w] <= div_step(stg[s].lane[w], stg[s].den);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/tetrahedral_barycentric_weights_core.sv */
// top level of the tetrahedral barycentric weights core
`default_nettype none

// Maps one signed Q1.14 color per request to its four barycentric weights
// (signed Q7.16, rounded half away from zero and saturated) in the tetrahedron
// whose vertices A, B, C, D sit in registers 0 to 3 of the cfg channel. A
// singular tetrahedron gives degenerate = 1 and all weights zero. The core
// takes one color every clock and keeps that rate for as long as the weights
// side takes results. A result passes through the six-stage determinant
// pipeline (edge subtract, cross product multiply and subtract, dot product
// multiply and sum, fourth determinant), two divider prep stages, the
// 24-stage restoring divider that yields one quotient bit per stage for all
// four weights, the rounding stage and the output register. A two-entry output
// buffer decouples the sides: color.ready stays high while a finished result
// waits and drops only once both entries are full, which freezes the whole
// pipeline without loss. Vertex registers may only be written while no color
// is in flight.

module tetrahedral_barycentric_weights_core import tbw_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  tbw_color_if.sink       color,
  tbw_weights_if.source   weights,
  tbw_cfg_if.sink         cfg
);

  gamut_t   gamut;
  color_t   in_color;
  logic     advance;

  logic     det_valid;
  det_res_t det_res;
  logic     div_valid;
  weights_t div_res;

  // output register and skid entry
  logic     out_valid;
  weights_t out_data;
  logic     skid_valid;
  weights_t skid_data;

  // the pipeline moves whenever the skid entry is free
  assign advance     = !skid_valid;
  assign color.ready = advance;

  assign in_color.color_red   = color.color_red;
  assign in_color.color_green = color.color_green;
  assign in_color.color_blue  = color.color_blue;

  tbw_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .gamut (gamut)
  );

  // edges, cross products and the five determinants
  tbw_det u_det (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (color.valid),
    .color     (in_color),
    .gamut     (gamut),
    .res_valid (det_valid),
    .res       (det_res)
  );

  // four quotients against the shared gamut determinant
  tbw_div u_div (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (det_valid),
    .in_det    (det_res),
    .res_valid (div_valid),
    .res       (div_res)
  );

  // skid buffer: a result that finds the output register stalled parks here
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || weights.ready) begin
        out_valid <= skid_valid || div_valid;
      end
      if (!skid_valid && div_valid && out_valid && !weights.ready) begin
        skid_valid <= 1'b1;
      end else if (skid_valid && weights.ready) begin
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || weights.ready) begin
      out_data <= skid_valid ? skid_data : div_res;
    end
    if (!skid_valid && div_valid && out_valid && !weights.ready) begin
      skid_data <= div_res;
    end
  end

  assign weights.valid      = out_valid;
  assign weights.weight_a   = out_data.weight_a;
  assign weights.weight_b   = out_data.weight_b;
  assign weights.weight_c   = out_data.weight_c;
  assign weights.weight_d   = out_data.weight_d;
  assign weights.degenerate = out_data.degenerate;

endmodule

`default_nettype wire

/* tb/tbw_weights_checker.sv */
// watches the core's request channels, predicts the weights of each color and compares them
`default_nettype none

module tbw_weights_checker import tbw_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  tbw_color_if   color,
  tbw_weights_if weights,
  tbw_cfg_if     cfg,
  output int     mismatches,
  output int     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned W_POS_MAX = (64'd1 << (OUT_W - 1)) - 1;
  localparam longint unsigned W_NEG_MAG = 64'd1 << (OUT_W - 1);

  typedef longint vec3_t [3];

  gamut_t   gamut;
  weights_t expected_weights [$];
  int       fail_total = 0;

  function automatic longint sign_extend(longint unsigned v);
    longint unsigned field;
    field = v & ((64'd1 << CW) - 1);
    if (field[CW-1]) return longint'(field) - (longint'(1) << CW);
    return longint'(field);
  endfunction

  function automatic longint vertex_comp(vertex_t v, int k);
    return sign_extend(longint'(v >> (CW * k)));
  endfunction

  // determinant of the matrix with columns x, y, z
  function automatic longint det3(input vec3_t x, input vec3_t y, input vec3_t z);
    return x[0] * (y[1] * z[2] - z[1] * y[2])
         - y[0] * (x[1] * z[2] - z[1] * x[2])
         + z[0] * (x[1] * y[2] - y[1] * x[2]);
  endfunction

  // num/den rounded half away from zero to q7.16, saturated
  function automatic weight_t round_weight(longint num, longint den);
    bit              neg;
    longint unsigned n, d, q, r, frac, mag;
    int              i;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? longint'(-num) : longint'(num);
    d = (den < 0) ? longint'(-den) : longint'(den);
    q = n / d;
    r = n % d;
    if (q >= (64'd1 << WQ_INT)) begin
      mag = W_NEG_MAG + 1;
    end else begin
      frac = 0;
      for (i = 0; i < WQ_FRAC; i++) begin
        r = r << 1;
        frac = frac << 1;
        if (r >= d) begin
          r = r - d;
          frac = frac | 64'd1;
        end
      end
      mag = (((q << WQ_FRAC) | frac) + 1) >> 1;
    end
    if (!neg) return weight_t'((mag > W_POS_MAX) ? W_POS_MAX : mag);
    return weight_t'(64'd0 - ((mag > W_NEG_MAG) ? W_NEG_MAG : mag));
  endfunction

  function automatic weights_t barycentric_weights(gamut_t gm, color_t c);
    vec3_t       ea, eb, ec, off;
    longint      dv, den, na, nb, nc, nd;
    color_comp_t pix [3];
    weights_t    w;
    int          k;
    pix[0] = c.color_red;
    pix[1] = c.color_green;
    pix[2] = c.color_blue;
    for (k = 0; k < NUM_COMP; k++) begin
      dv = vertex_comp(gm.vertex_d, k);
      ea[k] = vertex_comp(gm.vertex_a, k) - dv;
      eb[k] = vertex_comp(gm.vertex_b, k) - dv;
      ec[k] = vertex_comp(gm.vertex_c, k) - dv;
      off[k] = sign_extend(longint'(pix[k])) - dv;
    end
    w = '0;
    den = det3(ea, eb, ec);
    if (den == 0) begin
      w.degenerate = 1'b1;
      return w;
    end
    na = det3(off, eb, ec);
    nb = det3(ea, off, ec);
    nc = det3(ea, eb, off);
    nd = den - na - nb - nc;
    w.weight_a = round_weight(na, den);
    w.weight_b = round_weight(nb, den);
    w.weight_c = round_weight(nc, den);
    w.weight_d = round_weight(nd, den);
    return w;
  endfunction

  task automatic report_mismatch(string why, weights_t want, weights_t got);
    fail_total++;
    if (fail_total <= 10) begin
      $write("%0t weights mismatch (%s): expected a=%0d b=%0d c=%0d d=%0d deg=%0b,",
             $time, why, want.weight_a, want.weight_b, want.weight_c, want.weight_d,
             want.degenerate);
      $display(" got a=%0d b=%0d c=%0d d=%0d deg=%0b",
               got.weight_a, got.weight_b, got.weight_c, got.weight_d, got.degenerate);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    color_t   pix;
    weights_t got, want;
    if (rst) begin
      gamut = '0;
      expected_weights.delete();
    end else begin
      if (weights.valid && weights.ready) begin
        got.weight_a   = weights.weight_a;
        got.weight_b   = weights.weight_b;
        got.weight_c   = weights.weight_c;
        got.weight_d   = weights.weight_d;
        got.degenerate = weights.degenerate;
        if (expected_weights.size() == 0) begin
          report_mismatch("no request pending", '0, got);
        end else begin
          want = expected_weights.pop_front();
          if (got.weight_a !== want.weight_a || got.weight_b !== want.weight_b ||
              got.weight_c !== want.weight_c || got.weight_d !== want.weight_d ||
              got.degenerate !== want.degenerate)
            report_mismatch("field", want, got);
        end
      end
      if (color.valid && color.ready) begin
        pix.color_red   = color.color_red;
        pix.color_green = color.color_green;
        pix.color_blue  = color.color_blue;
        expected_weights.push_back(barycentric_weights(gamut, pix));
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_VERTEX_A: gamut.vertex_a = cfg.data;
          REG_VERTEX_B: gamut.vertex_b = cfg.data;
          REG_VERTEX_C: gamut.vertex_c = cfg.data;
          REG_VERTEX_D: gamut.vertex_d = cfg.data;
          default: ;
        endcase
      end
    end
    mismatches  <= fail_total;
    outstanding <= expected_weights.size();
  end

endmodule

`default_nettype wire

/* tb/tetrahedral_barycentric_weights_core_tb.sv */
// stimulus and verdict for the tetrahedral barycentric weights core
`default_nettype none

module tetrahedral_barycentric_weights_core_tb import tbw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // pipeline wait that settle adds once every result is back
  localparam int LATENCY       = 33;
  // receiver hold-off that fills the pipeline and the output buffer
  localparam int HOLD_CYCLES   = 300;
  // cycles without any accepted request before the run is declared hung
  localparam int IDLE_LIMIT    = 4000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 80;

  typedef enum int {
    GAMUT_RANDOM,
    GAMUT_TIGHT,
    GAMUT_FLAT,
    GAMUT_WIDE,
    GAMUT_CORNERS
  } gamut_kind_e;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   idle_cycles = 0;
  bit   no_idle = 1'b0;        // both sides run without gaps
  bit   long_hold_req = 1'b0;  // ask the receiver for one long hold-off

  tbw_color_if   color_if ();
  tbw_weights_if weights_if ();
  tbw_cfg_if     cfg_if ();

  tetrahedral_barycentric_weights_core u_top (
    .clk     (clk),
    .rst     (rst),
    .color   (color_if),
    .weights (weights_if),
    .cfg     (cfg_if)
  );

  tbw_weights_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .color       (color_if),
    .weights     (weights_if),
    .cfg         (cfg_if),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // three components, red in the lowest bits
  function automatic vertex_t pack_vertex(int red, int green, int blue);
    vertex_t mask;
    mask = (vertex_t'(1) << CW) - 1;
    return (vertex_t'(red) & mask) | ((vertex_t'(green) & mask) << CW) |
           ((vertex_t'(blue) & mask) << (2 * CW));
  endfunction

  function automatic int spread(int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  function automatic gamut_t random_gamut();
    gamut_t      g;
    gamut_kind_e kind;
    int          d [3], a [3], b [3], c [3];
    int          span, k;
    kind = gamut_kind_e'($urandom_range(0, 4));
    span = (kind == GAMUT_TIGHT) ? 64 : 12000;
    for (k = 0; k < 3; k++) begin
      d[k] = spread(8000);
      a[k] = d[k] + spread(span);
      b[k] = d[k] + spread(span);
      c[k] = d[k] + spread(span);
      if (kind == GAMUT_FLAT) begin
        // c - d is the sum of the edges a - d and b - d, so the tetrahedron is flat
        a[k] = d[k] + spread(4000);
        b[k] = d[k] + spread(4000);
        c[k] = a[k] + b[k] - d[k];
      end
    end
    g.vertex_a = pack_vertex(a[0], a[1], a[2]);
    g.vertex_b = pack_vertex(b[0], b[1], b[2]);
    g.vertex_c = pack_vertex(c[0], c[1], c[2]);
    g.vertex_d = pack_vertex(d[0], d[1], d[2]);
    case (kind)
      GAMUT_RANDOM: begin
        g.vertex_a = vertex_t'({$urandom(), $urandom()});
        g.vertex_b = vertex_t'({$urandom(), $urandom()});
        g.vertex_c = vertex_t'({$urandom(), $urandom()});
        g.vertex_d = vertex_t'({$urandom(), $urandom()});
      end
      GAMUT_CORNERS: begin
        // every component at one end of its range
        g.vertex_a = '0;
        g.vertex_b = '0;
        g.vertex_c = '0;
        g.vertex_d = '0;
        for (k = 0; k < 3; k++) begin
          g.vertex_a |= pack_vertex($urandom_range(0, 1) ? 32767 : -32768, 0, 0) << (CW * k);
          g.vertex_b |= pack_vertex($urandom_range(0, 1) ? 32767 : -32768, 0, 0) << (CW * k);
          g.vertex_c |= pack_vertex($urandom_range(0, 1) ? 32767 : -32768, 0, 0) << (CW * k);
          g.vertex_d |= pack_vertex($urandom_range(0, 1) ? 32767 : -32768, 0, 0) << (CW * k);
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input vertex_t val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // all four vertices, then a write to an unused index that must be dropped
  task automatic load_gamut(input vertex_t a, input vertex_t b, input vertex_t c,
                            input vertex_t d);
    write_reg(REG_VERTEX_A, a);
    write_reg(REG_VERTEX_B, b);
    write_reg(REG_VERTEX_C, c);
    write_reg(REG_VERTEX_D, d);
    write_reg(CFG_IDX_W'($urandom_range(REG_VERTEX_D + 1, 2 ** CFG_IDX_W - 1)),
              vertex_t'({$urandom(), $urandom()}));
    cfg_if.valid <= 1'b0;
  endtask

  // one color request, with an optional gap in front of it
  task automatic send_color(input color_comp_t red, input color_comp_t green,
                            input color_comp_t blue);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      color_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    color_if.valid       <= 1'b1;
    color_if.color_red   <= red;
    color_if.color_green <= green;
    color_if.color_blue  <= blue;
    @(posedge clk);
    while (!color_if.ready) @(posedge clk);
  endtask

  // mostly full range, some near a vertex, some at the range ends
  task automatic send_random_color(input gamut_t g);
    color_comp_t c [3];
    vertex_t     near;
    int          sel, k;
    sel = $urandom_range(0, 9);
    near = $urandom_range(0, 1) ? g.vertex_d : g.vertex_a;
    for (k = 0; k < 3; k++) begin
      if (sel < 7) c[k] = color_comp_t'($urandom());
      else if (sel < 9) c[k] = color_comp_t'(near >> (CW * k)) + color_comp_t'(spread(32));
      else c[k] = color_comp_t'($urandom_range(0, 1) ? 32767 : -32768);
    end
    send_color(c[0], c[1], c[2]);
  endtask

  // stop offering colors, let every result come back, then let the pipe empty
  task automatic settle();
    color_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // receiver: runs of ready with random gaps, and one long hold-off on request
  initial begin : receiver
    int run_len, gap;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        weights_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        run_len = no_idle ? 16 : $urandom_range(1, 12);
        weights_if.ready <= 1'b1;
        repeat (run_len) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          weights_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // watchdog: ends the run when no request moves on any channel for too long
  always @(posedge clk) begin
    if ((color_if.valid && color_if.ready) || (weights_if.valid && weights_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    gamut_t g;
    int     k, i;
    rst                  <= 1'b1;
    color_if.valid       <= 1'b0;
    color_if.color_red   <= '0;
    color_if.color_green <= '0;
    color_if.color_blue  <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= '0;
    cfg_if.data          <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // registers still at reset: all vertices at the origin, so singular
    send_color(0, 0, 0);
    send_color(32767, -32768, 32767);
    settle();

    // unit axes from the origin: weights a, b and c equal the color components
    load_gamut(pack_vertex(16384, 0, 0), pack_vertex(0, 16384, 0),
               pack_vertex(0, 0, 16384), pack_vertex(0, 0, 0));
    send_color(0, 0, 0);
    send_color(16384, 0, 0);
    send_color(0, 16384, 0);
    send_color(0, 0, 16384);
    send_color(32767, 32767, 32767);
    send_color(-32768, -32768, -32768);
    settle();

    // edges of one lsb: weights hit both saturation limits
    load_gamut(pack_vertex(1, 0, 0), pack_vertex(0, 1, 0),
               pack_vertex(0, 0, 1), pack_vertex(0, 0, 0));
    send_color(32767, 0, 0);
    send_color(-32768, 0, 0);
    send_color(127, -128, 0);
    send_color(128, -129, 1);
    send_color(1, 1, 1);
    send_color(0, 0, 0);
    settle();

    // determinant of 2^17: odd numerators land exactly halfway between codes
    load_gamut(pack_vertex(300, -24688, 0), pack_vertex(1, 16684, 0),
               pack_vertex(0, 16384, 1), pack_vertex(0, 16384, 0));
    send_color(0, 16383, 0);
    send_color(0, 16385, 0);
    send_color(0, 16381, 0);
    send_color(0, 16387, 0);
    settle();

    // widest tetrahedron the components allow
    load_gamut(pack_vertex(32767, -32768, -32768), pack_vertex(-32768, 32767, -32768),
               pack_vertex(-32768, -32768, 32767), pack_vertex(-32768, -32768, -32768));
    send_color(32767, 32767, 32767);
    send_color(-32768, -32768, -32768);
    send_color(0, 0, 0);
    settle();

    // two equal vertices: flat gamut
    load_gamut(pack_vertex(100, 200, 300), pack_vertex(100, 200, 300),
               pack_vertex(-5, 7, 9), pack_vertex(1, 2, 3));
    send_color(4000, -4000, 123);
    send_color(-1, -1, -1);

    // random gamuts, each with a burst of colors; some phases without gaps,
    // some with a long receiver hold-off while colors keep coming
    for (k = 0; k < RANDOM_PHASES; k++) begin
      settle();
      g = random_gamut();
      load_gamut(g.vertex_a, g.vertex_b, g.vertex_c, g.vertex_d);
      no_idle = (k % 4 == 3);
      if (k % 6 == 1) long_hold_req = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) send_random_color(g);
    end
    no_idle = 1'b0;
    settle();

    if (mismatches == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
